// ----- rtl/utf8_atom_segmenter_unit_defines.svh -----
// ----------------------------------------------------------------------------
// utf8 atom segmenter assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef UTF8_ATOM_SEGMENTER_UNIT_DEFINES_SVH
`define UTF8_ATOM_SEGMENTER_UNIT_DEFINES_SVH

// checked outside reset only
`define UAS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define UAS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/utf8as_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8as_pkg
// types, codes and defaults shared by the utf8 atom segmenter
// ----------------------------------------------------------------------------
package utf8as_pkg;

	localparam int DEF_MAX_RUN     = 255;
	localparam int DEF_QUEUE_DEPTH = 4;

	// atom kind codes
	localparam logic [2:0] KIND_ASCII = 3'd0;
	localparam logic [2:0] KIND_TWO   = 3'd1;
	localparam logic [2:0] KIND_THREE = 3'd2;
	localparam logic [2:0] KIND_FOUR  = 3'd3;
	localparam logic [2:0] KIND_ERR   = 3'd4;

	typedef struct packed {
		logic [7:0] atom_length;
		logic [2:0] atom_kind;
		logic       text_done;
	} result_t;

	// all results caused by one byte
	typedef struct packed {
		result_t first;
		result_t second;
		logic    has_second;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} q_wr_t;

	typedef struct packed {
		logic   empty;
		entry_t entry;
	} q_rd_t;

endpackage

// ----- rtl/utf8as_in_if.sv -----
// ----------------------------------------------------------------------------
// utf8as_in_if
// text byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface utf8as_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, text_byte, end_of_text, input ready);
	modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

// ----- rtl/utf8as_out_if.sv -----
// ----------------------------------------------------------------------------
// utf8as_out_if
// atom result channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface utf8as_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] atom_length;
	logic [2:0] atom_kind;
	logic       text_done;

	modport source (output valid, atom_length, atom_kind, text_done, input ready);
	modport sink   (input valid, atom_length, atom_kind, text_done, output ready);
endinterface

// ----- rtl/utf8_atom_segmenter_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_atom_segmenter_unit
// cuts a byte stream into ascii word runs, single bytes and utf-8 characters
// ----------------------------------------------------------------------------
// One text byte is taken per cycle on text_in while the result queue has room.
// The classifier updates its run / sequence state and writes every result the
// byte causes (none, one or two) into a queue entry in the same cycle. The
// result sequencer unloads one result per cycle into the output register while
// atom_out is not stalled, so a result passes the queue memory and the output
// register on its way to atom_out. The single output port sets the sustained
// rate: a byte that both ends a word run and forms its own atom or error
// yields two results, which leave one at a time; the queue soaks up such bursts.
// Word runs are cut at min(MAX_RUN, 255) bytes. After an encoding error the
// unit drops bytes silently until end_of_text, then starts clean.
// ----------------------------------------------------------------------------
module utf8_atom_segmenter_unit
	import utf8as_pkg::*;
#(
	parameter int MAX_RUN     = DEF_MAX_RUN,     // 4 .. 65535
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH  // entries, at least 2
) (
	input  logic         clk,
	input  logic         arst_n,
	utf8as_in_if.sink    text_in,
	utf8as_out_if.source atom_out
);

	// classifier to queue
	q_wr_t q_wr;
	logic  q_full;

	// queue to sequencer
	q_rd_t q_rd;
	logic  q_pop;

	// front: byte transfer, state tracking, entry forming
	utf8as_front #(
		.MAX_RUN (MAX_RUN)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in),
		.q_full  (q_full),
		.q_wr    (q_wr)
	);

	// decoupling queue, one entry per byte with results
	utf8as_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.full   (q_full),
		.pop    (q_pop),
		.rd     (q_rd)
	);

	// back: one result per output transfer, second result held aside
	utf8as_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rd     (q_rd),
		.q_pop    (q_pop),
		.atom_out (atom_out)
	);

endmodule

// ----- rtl/utf8as_fifo.sv -----
// ----------------------------------------------------------------------------
// utf8as_fifo
// short entry queue between classifier and result sequencer
// ----------------------------------------------------------------------------
module utf8as_fifo
	import utf8as_pkg::*;
#(
	parameter int DEPTH = DEF_QUEUE_DEPTH  // at least 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  q_wr_t wr,
	output logic  full,
	input  logic  pop,
	output q_rd_t rd
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd.empty = (count_q == '0);
	assign rd.entry = mem_q[rd_ptr_q];
	assign do_push  = wr.push && !full;
	assign do_pop   = pop && !rd.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/utf8as_front.sv -----
// ----------------------------------------------------------------------------
// utf8as_front
// byte classifier: tracks runs and utf-8 sequences, forms result entries
// ----------------------------------------------------------------------------
module utf8as_front
	import utf8as_pkg::*;
#(
	parameter int MAX_RUN = DEF_MAX_RUN
) (
	input  logic             clk,
	input  logic             arst_n,
	utf8as_in_if.sink        text_in,
	input  logic             q_full,
	output q_wr_t            q_wr
);

	localparam logic [7:0] RUN_CAP = (MAX_RUN > 255) ? 8'd255 : 8'(MAX_RUN);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_RUN  = 4'b0010,
		PH_SEQ  = 4'b0100,
		PH_SKIP = 4'b1000
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [1:0] expect_q, expect_d;
	logic [7:0] run_q, run_d;
	logic [1:0] pkind_q, pkind_d;

	logic       accept;
	logic [7:0] b;
	logic       eot;
	logic       word;
	logic       cont;
	logic [1:0] expect_dec;
	logic [7:0] run_new;
	logic       flush_v;
	logic       own_v;
	result_t    flush_res;
	result_t    own_res;

	assign accept       = text_in.valid && text_in.ready;
	assign text_in.ready = !q_full;
	assign b            = text_in.text_byte;
	assign eot          = text_in.end_of_text;
	assign cont         = (b[7:6] == 2'b10);
	assign expect_dec   = expect_q - 2'd1;

	always_comb begin
		word = 1'b0;
		if (b inside {[8'h30:8'h39], [8'h40:8'h5A], [8'h61:8'h7A], 8'h2D, 8'h2E}) begin
			word = 1'b1;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		expect_d = expect_q;
		run_d    = run_q;
		pkind_d  = pkind_q;
		run_new  = (phase_q == PH_RUN) ? run_q + 8'd1 : 8'd1;
		flush_v  = 1'b0;
		own_v    = 1'b0;
		own_res  = '{atom_length: 8'd0, atom_kind: KIND_ERR, text_done: 1'b0};
		case (phase_q)
			PH_SKIP: begin
				phase_d = PH_SKIP;
			end
			PH_SEQ: begin
				if (cont) begin
					expect_d = expect_dec;
					if (expect_dec == 2'd0) begin
						own_v   = 1'b1;
						own_res = '{atom_length: {6'd0, pkind_q} + 8'd1,
							atom_kind: {1'b0, pkind_q}, text_done: 1'b0};
						phase_d = PH_IDLE;
					end else if (eot) begin
						// text ends inside the sequence
						own_v = 1'b1;
					end
				end else begin
					own_v   = 1'b1;
					phase_d = PH_SKIP;
				end
			end
			default: begin
				if (!b[7]) begin
					if (word) begin
						run_d   = run_new;
						phase_d = PH_RUN;
						if (run_new >= RUN_CAP || eot) begin
							own_v   = 1'b1;
							own_res = '{atom_length: run_new, atom_kind: KIND_ASCII,
								text_done: 1'b0};
							run_d   = 8'd0;
							phase_d = PH_IDLE;
						end
					end else begin
						flush_v = (phase_q == PH_RUN);
						own_v   = 1'b1;
						own_res = '{atom_length: 8'd1, atom_kind: KIND_ASCII, text_done: 1'b0};
						run_d   = 8'd0;
						phase_d = PH_IDLE;
					end
				end else begin
					flush_v = (phase_q == PH_RUN);
					run_d   = 8'd0;
					phase_d = PH_SEQ;
					if (b[7:5] == 3'b110) begin
						pkind_d  = 2'd1;
						expect_d = 2'd1;
					end else if (b[7:4] == 4'b1110) begin
						pkind_d  = 2'd2;
						expect_d = 2'd2;
					end else if (b[7:3] == 5'b11110) begin
						pkind_d  = 2'd3;
						expect_d = 2'd3;
					end else begin
						// stray continuation or invalid lead
						own_v   = 1'b1;
						phase_d = PH_SKIP;
					end
					if (eot && phase_d == PH_SEQ) begin
						own_v = 1'b1;
					end
				end
			end
		endcase
		if (eot) begin
			phase_d  = PH_IDLE;
			expect_d = 2'd0;
			run_d    = 8'd0;
			pkind_d  = 2'd0;
		end
	end

	assign flush_res = '{atom_length: run_q, atom_kind: KIND_ASCII, text_done: 1'b0};

	always_comb begin
		q_wr.push  = accept && (flush_v || own_v);
		q_wr.entry = '0;
		if (flush_v) begin
			q_wr.entry.first      = flush_res;
			q_wr.entry.second     = own_res;
			q_wr.entry.has_second = own_v;
			if (own_v) begin
				q_wr.entry.second.text_done = eot;
			end else begin
				q_wr.entry.first.text_done = eot;
			end
		end else begin
			q_wr.entry.first           = own_res;
			q_wr.entry.first.text_done = eot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			expect_q <= 2'd0;
			run_q    <= 8'd0;
			pkind_q  <= 2'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			expect_q <= expect_d;
			run_q    <= run_d;
			pkind_q  <= pkind_d;
		end
	end

endmodule

// ----- rtl/utf8as_back.sv -----
// ----------------------------------------------------------------------------
// utf8as_back
// result sequencer: unpacks queue entries into one result per transfer
// ----------------------------------------------------------------------------
module utf8as_back
	import utf8as_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  q_rd_t       q_rd,
	output logic        q_pop,
	utf8as_out_if.source atom_out
);

	logic    out_valid_q;
	result_t out_res_q;
	logic    hold_valid_q;
	result_t hold_res_q;
	logic    load;

	assign load  = !out_valid_q || atom_out.ready;
	assign q_pop = load && !hold_valid_q && !q_rd.empty;

	assign atom_out.valid       = out_valid_q;
	assign atom_out.atom_length = out_res_q.atom_length;
	assign atom_out.atom_kind   = out_res_q.atom_kind;
	assign atom_out.text_done   = out_res_q.text_done;

	always_ff @(posedge clk) begin
		if (load) begin
			if (hold_valid_q) begin
				out_res_q <= hold_res_q;
			end else if (!q_rd.empty) begin
				out_res_q  <= q_rd.entry.first;
				hold_res_q <= q_rd.entry.second;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (load) begin
			if (hold_valid_q) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= 1'b0;
			end else if (!q_rd.empty) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= q_rd.entry.has_second;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/utf8as_checker.sv -----
// ----------------------------------------------------------------------------
// utf8as_checker
// port-level assertions for the utf8 atom segmenter
// ----------------------------------------------------------------------------
`include "utf8_atom_segmenter_unit_defines.svh"

module utf8as_checker
	import utf8as_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_length,
	input logic [2:0] out_kind,
	input logic       out_done
);

	`UAS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_length) && $stable(out_kind) && $stable(out_done), "stalled result changed")
	`UAS_ASSERT(a_err_len, out_valid && out_kind == KIND_ERR |-> out_length == 8'd0, "error result with nonzero length")
	`UAS_ASSERT(a_atom_len, out_valid && out_kind != KIND_ERR |-> out_length != 8'd0, "atom with zero length")
	`UAS_ASSERT(a_seq_len, out_valid |-> (out_kind != KIND_TWO || out_length == 8'd2) && (out_kind != KIND_THREE || out_length == 8'd3) && (out_kind != KIND_FOUR || out_length == 8'd4), "utf-8 atom length does not match kind")
	`UAS_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !out_valid, "result offered during reset")

endmodule

bind utf8_atom_segmenter_unit utf8as_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (atom_out.valid),
	.out_ready  (atom_out.ready),
	.out_length (atom_out.atom_length),
	.out_kind   (atom_out.atom_kind),
	.out_done   (atom_out.text_done)
);

// ----- tb/sv/utf8_atom_checker.sv -----
// ----------------------------------------------------------------------------
// utf8 atom checker
// watches both channels of the segmenter, predicts the atoms of every
// accepted text byte and compares each result transfer in order
// ----------------------------------------------------------------------------
module utf8_atom_checker
	import utf8as_pkg::*;
#(
	parameter int MAX_RUN = DEF_MAX_RUN
) (
	input  logic  clk,
	input  logic  arst_n,
	utf8as_in_if  text_mon,
	utf8as_out_if atom_mon,
	output int    fail_count,
	output int    outstanding
);

	localparam int RUN_CAP = (MAX_RUN > 255) ? 255 : MAX_RUN;

	typedef enum logic [1:0] {SEG_IDLE, SEG_RUN, SEG_SEQ, SEG_SKIP} seg_phase_t;

	seg_phase_t seg_phase;
	logic [1:0] cont_left;
	logic [7:0] run_len;
	logic [2:0] seq_kind;
	result_t    expected_atoms[$];

	function automatic logic is_word(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h40 && b <= 8'h5A) ||
			(b >= 8'h61 && b <= 8'h7A) || b == 8'h2D || b == 8'h2E;
	endfunction

	function automatic result_t make_atom(input logic [7:0] len, input logic [2:0] kind);
		result_t r;
		r.atom_length = len;
		r.atom_kind   = kind;
		r.text_done   = 1'b0;
		return r;
	endfunction

	task automatic clear_segmenter();
		seg_phase = SEG_IDLE;
		cont_left = 2'd0;
		run_len   = 8'd0;
		seq_kind  = 3'd0;
	endtask

	task automatic predict_atoms(input logic [7:0] b, input logic last);
		result_t res[2];
		int      n;
		n = 0;
		case (seg_phase)
			SEG_SKIP: ;
			SEG_SEQ: begin
				if (b[7:6] == 2'b10) begin
					cont_left = cont_left - 2'd1;
					if (cont_left == 2'd0) begin
						res[n] = make_atom(8'(seq_kind) + 8'd1, seq_kind);
						n++;
						seg_phase = SEG_IDLE;
					end
				end else begin
					res[n] = make_atom(8'd0, KIND_ERR);
					n++;
					seg_phase = SEG_SKIP;
				end
				if (last && seg_phase == SEG_SEQ) begin
					res[n] = make_atom(8'd0, KIND_ERR);
					n++;
				end
			end
			default: begin
				if (!b[7] && is_word(b)) begin
					if (seg_phase == SEG_RUN) begin
						run_len = run_len + 8'd1;
					end else begin
						run_len   = 8'd1;
						seg_phase = SEG_RUN;
					end
					if (int'(run_len) >= RUN_CAP || last) begin
						res[n] = make_atom(run_len, KIND_ASCII);
						n++;
						run_len   = 8'd0;
						seg_phase = SEG_IDLE;
					end
				end else if (!b[7]) begin
					// a pending run goes out ahead of the byte's own atom
					if (seg_phase == SEG_RUN) begin
						res[n] = make_atom(run_len, KIND_ASCII);
						n++;
					end
					res[n] = make_atom(8'd1, KIND_ASCII);
					n++;
					run_len   = 8'd0;
					seg_phase = SEG_IDLE;
				end else begin
					if (seg_phase == SEG_RUN) begin
						res[n] = make_atom(run_len, KIND_ASCII);
						n++;
					end
					run_len   = 8'd0;
					seg_phase = SEG_SEQ;
					casez (b)
						8'b110?????: begin
							seq_kind  = KIND_TWO;
							cont_left = 2'd1;
						end
						8'b1110????: begin
							seq_kind  = KIND_THREE;
							cont_left = 2'd2;
						end
						8'b11110???: begin
							seq_kind  = KIND_FOUR;
							cont_left = 2'd3;
						end
						default: begin
							res[n] = make_atom(8'd0, KIND_ERR);
							n++;
							seg_phase = SEG_SKIP;
						end
					endcase
					if (last && seg_phase == SEG_SEQ) begin
						res[n] = make_atom(8'd0, KIND_ERR);
						n++;
					end
				end
			end
		endcase
		if (last) begin
			if (n > 0)
				res[n - 1].text_done = 1'b1;
			clear_segmenter();
		end
		for (int i = 0; i < n; i++)
			expected_atoms.push_back(res[i]);
	endtask

	task automatic check_atom();
		result_t want;
		if (expected_atoms.size() == 0) begin
			$error("unexpected atom: atom_length %0d atom_kind %0d text_done %0b",
				atom_mon.atom_length, atom_mon.atom_kind, atom_mon.text_done);
			fail_count++;
		end else begin
			want = expected_atoms.pop_front();
			if (atom_mon.atom_length !== want.atom_length) begin
				$error("atom_length: expected %0d, got %0d", want.atom_length,
					atom_mon.atom_length);
				fail_count++;
			end
			if (atom_mon.atom_kind !== want.atom_kind) begin
				$error("atom_kind: expected %0d, got %0d", want.atom_kind,
					atom_mon.atom_kind);
				fail_count++;
			end
			if (atom_mon.text_done !== want.text_done) begin
				$error("text_done: expected %0b, got %0b", want.text_done,
					atom_mon.text_done);
				fail_count++;
			end
		end
	endtask

	// results never leave in the cycle of their byte, so checking first is safe
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_segmenter();
			expected_atoms.delete();
			fail_count  = 0;
			outstanding <= 0;
		end else begin
			if (atom_mon.valid === 1'b1 && atom_mon.ready === 1'b1)
				check_atom();
			if (text_mon.valid === 1'b1 && text_mon.ready === 1'b1)
				predict_atoms(text_mon.text_byte, text_mon.end_of_text);
			outstanding <= expected_atoms.size();
		end
	end

endmodule

// ----- tb/sv/utf8_atom_segmenter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// utf8 atom segmenter unit testbench
// feeds directed and random texts through the segmenter with random gaps and
// stalls; the atom checker beside the unit predicts and compares every result
// ----------------------------------------------------------------------------
module utf8_atom_segmenter_unit_tb;
	import utf8as_pkg::*;

	// byte count of the random part; noise after a fault is not counted
	localparam int TEXT_BYTES   = 1350;
	// worst case is far below this: two results per byte, full stalls and gaps
	localparam int CYCLE_LIMIT  = 400000;
	// extra wait for stray results after the last predicted one; leave ample slack
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;

	utf8as_in_if  text_if();
	utf8as_out_if atom_if();

	int fail_count;
	int outstanding;
	int cycle_count = 0;

	// idle odds in percent per transfer / per cycle, changed per text
	int send_gap_pct = 0;
	int stall_pct    = 0;

	logic [7:0] text_q[$];
	logic       long_run_due = 1'b1;

	// directed bytes: bit 8 marks the final byte of a text
	logic [8:0] directed_q[$] = '{
		9'h000,                         // zero byte is a plain one-byte atom
		9'h061, 9'h05A, 9'h020,         // run cut by a space: two results at once
		9'h039, 9'h0C3, 9'h0A9,         // run cut by a two-byte character
		9'h0E2, 9'h082, 9'h0AC,         // three-byte character
		9'h0F0, 9'h09F, 9'h098, 9'h080, // four-byte character
		9'h080, 9'h141,                 // continuation byte as lead, rest skipped
		9'h0C3, 9'h041, 9'h1FF,         // bad continuation, then skip to the end
		9'h0E2, 9'h182,                 // text ends inside a sequence
		9'h02E, 9'h12D,                 // word run closed by the final byte
		9'h1F8,                         // bad lead on the final byte
		9'h040, 9'h17F                  // run cut by a final non-word byte
	};

	utf8_atom_segmenter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_if),
		.atom_out (atom_if)
	);

	utf8_atom_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_mon    (text_if),
		.atom_mon    (atom_if),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop in case the unit hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("utf8_atom_segmenter_unit_tb: FAIL");
			$finish;
		end
	end

	// ---- byte generators ----

	function automatic logic [7:0] word_byte();
		case ($urandom_range(0, 4))
			0: return 8'($urandom_range(8'h30, 8'h39));
			1: return 8'($urandom_range(8'h40, 8'h5A));
			2: return 8'($urandom_range(8'h61, 8'h7A));
			3: return 8'h2D;
			default: return 8'h2E;
		endcase
	endfunction

	// ascii bytes that stand as atoms of their own
	function automatic logic [7:0] punct_byte();
		case ($urandom_range(0, 4))
			0: return 8'($urandom_range(8'h00, 8'h2C));
			1: return 8'h2F;
			2: return 8'($urandom_range(8'h3A, 8'h3F));
			3: return 8'($urandom_range(8'h5B, 8'h60));
			default: return 8'($urandom_range(8'h7B, 8'h7F));
		endcase
	endfunction

	function automatic logic [7:0] lead_byte(input int size);
		case (size)
			2: return {3'b110, 5'($urandom)};
			3: return {4'b1110, 4'($urandom)};
			default: return {5'b11110, 3'($urandom)};
		endcase
	endfunction

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	// anything but 10xxxxxx where a continuation belongs
	function automatic logic [7:0] bad_cont_byte();
		case ($urandom_range(0, 2))
			0: return {2'b00, 6'($urandom)};
			1: return {2'b01, 6'($urandom)};
			default: return {2'b11, 6'($urandom)};
		endcase
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 3))
			0, 1: return 0;
			2: return 5;
			default: return 25;
		endcase
	endfunction

	// one text of a few tokens; most are well formed, about one token in ten is
	// a fault, after which the text ends or trails off in ignored noise
	task automatic build_text(output int counted);
		int   ntok;
		int   pick;
		int   len;
		int   size;
		int   noise;
		logic faulted;
		logic truncated;
		text_q.delete();
		faulted   = 1'b0;
		truncated = 1'b0;
		ntok      = $urandom_range(1, 8);
		for (int t = 0; t < ntok && !faulted; t++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				// the occasional long run crosses the saturation length
				if (long_run_due || $urandom_range(0, 249) == 0) begin
					len          = $urandom_range(250, 262);
					long_run_due = 1'b0;
				end else begin
					len = $urandom_range(1, 12);
				end
				repeat (len) text_q.push_back(word_byte());
			end else if (pick < 55) begin
				text_q.push_back(punct_byte());
			end else if (pick < 90) begin
				size = $urandom_range(2, 4);
				text_q.push_back(lead_byte(size));
				repeat (size - 1) text_q.push_back(cont_byte());
			end else begin
				faulted = 1'b1;
				size    = $urandom_range(2, 4);
				case ($urandom_range(0, 2))
					0: begin
						// continuation or 11111xxx in lead position
						if ($urandom_range(0, 1))
							text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
						else
							text_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
					end
					1: begin
						text_q.push_back(lead_byte(size));
						repeat ($urandom_range(0, size - 2)) text_q.push_back(cont_byte());
						text_q.push_back(bad_cont_byte());
					end
					default: begin
						// sequence cut short by the end of the text
						text_q.push_back(lead_byte(size));
						repeat ($urandom_range(0, size - 2)) text_q.push_back(cont_byte());
						truncated = 1'b1;
					end
				endcase
			end
		end
		counted = text_q.size();
		if (faulted && !truncated) begin
			noise = $urandom_range(0, 5);
			repeat (noise) text_q.push_back(8'($urandom));
		end
	endtask

	// ---- drivers ----

	// valid stays high into the next byte unless a gap is drawn
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if ($urandom_range(1, 100) <= send_gap_pct) begin
			gap = $urandom_range(1, 13);
			text_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_if.valid       <= 1'b1;
		text_if.text_byte   <= b;
		text_if.end_of_text <= last;
		do @(posedge clk); while (text_if.ready !== 1'b1);
	endtask

	// result side: ready high except in random stall bursts
	initial begin : result_sink
		int burst;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ($urandom_range(1, 100) <= stall_pct) begin
				atom_if.ready <= 1'b0;
				burst = $urandom_range(1, 13);
				repeat (burst) @(posedge clk);
			end
			atom_if.ready <= 1'b1;
		end
	end

	// ---- main sequence ----

	initial begin : stimulus
		int sent_bytes;
		int counted;
		// every input known from time zero
		arst_n              = 1'b0;
		text_if.valid       = 1'b0;
		text_if.text_byte   = 8'h00;
		text_if.end_of_text = 1'b0;
		atom_if.ready       = 1'b0;
		sent_bytes          = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part with light idling on both sides
		send_gap_pct = 10;
		stall_pct    = 10;
		foreach (directed_q[i])
			send_byte(directed_q[i][7:0], directed_q[i][8]);

		// random texts; idling settles to nothing for the tail of the run
		while (sent_bytes < TEXT_BYTES) begin
			build_text(counted);
			if (sent_bytes + counted > TEXT_BYTES - 150) begin
				send_gap_pct = 0;
				stall_pct    = 0;
			end else begin
				send_gap_pct = pick_idle_pct();
				stall_pct    = pick_idle_pct();
			end
			foreach (text_q[i])
				send_byte(text_q[i], i == text_q.size() - 1);
			sent_bytes += counted;
		end
		text_if.valid <= 1'b0;

		// let every predicted atom arrive, then watch for strays
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("utf8_atom_segmenter_unit_tb: PASS");
		else
			$display("utf8_atom_segmenter_unit_tb: FAIL");
		$finish;
	end

endmodule
